[hw/rtl/ordf_pkg.sv]
// ordf_pkg: shared types and constants for the object record deframer.
// Used by ordf_back and object_record_deframer_core; depends on nothing.
package ordf_pkg;

	// Record walk phase; PH_DIV waits on the block boundary remainder
	typedef enum logic [2:0] {
		PH_STOP  = 3'd0,
		PH_TYPE  = 3'd1,
		PH_LENLO = 3'd2,
		PH_LENHI = 3'd3,
		PH_BODY  = 3'd4,
		PH_PAD   = 3'd5,
		PH_DIV   = 3'd6
	} phase_t;

	// Per-byte classification reported on the result channel
	typedef enum logic [3:0] {
		EV_HEADER  = 4'd0,
		EV_PAYLOAD = 4'd1,
		EV_OK      = 4'd2,
		EV_CSUM    = 4'd3,
		EV_LONG    = 4'd4,
		EV_REPEAT  = 4'd5,
		EV_PAD     = 4'd6,
		EV_STOPPED = 4'd7,
		EV_ZERO    = 4'd8
	} event_t;

	// Result fields other than the record offset
	typedef struct packed {
		event_t      ev;
		logic [7:0]  rtype;
		logic [7:0]  pbyte;
		logic [15:0] pidx;
		logic [15:0] rlen;
		logic [16:0] blk;
		logic        eor;
	} result_t;

	localparam logic [7:0]  TYPE_LIB_HDR  = 8'hF0;
	localparam logic [7:0]  TYPE_LIB_END  = 8'hF1;
	localparam logic [7:0]  TYPE_MOD_END  = 8'h8A;
	localparam logic [7:0]  MOD_END_MASK  = 8'hFE;
	localparam logic [16:0] LIB_HDR_EXTRA = 17'd3;
	localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

endpackage

[hw/rtl/object_record_deframer_core.sv]
// object_record_deframer_core: top level of the object record deframer.
// Depends on ordf_pkg, ordf_front, ordf_queue and ordf_back.

// Splits an object or library file, fed one byte per transaction, into
// records (type byte, little-endian length with checksum, payload, checksum)
// and returns one classified result per byte. Each accepted byte passes
// through the queue and then the back end's result register to out_valid.
// Throughput is one byte per cycle while out_stall is low. The exception is
// a module-end record when a library block size is known: the pad count
// comes from the file offset modulo the block size, which the back end's
// remainder unit works out one offset bit per cycle, holding the back end;
// the two-entry queue then fills and in_stall rises.
// The block is stopped after reset and ignores bytes (event 7) until a byte
// arrives with start_of_file set. max_record_length is written through
// cfg_wr_en/cfg_wr_data and should only change while no transaction is
// in flight.
module object_record_deframer_core
	import ordf_pkg::*;
#(
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_wr_en,
	input  logic [15:0]            cfg_wr_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             stream_byte,
	input  logic                   start_of_file,
	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [3:0]             event_res,
	output logic [7:0]             record_type,
	output logic [7:0]             payload_byte,
	output logic [15:0]            payload_index,
	output logic [15:0]            record_length,
	output logic [OFFSET_BITS-1:0] record_offset,
	output logic [16:0]            block_size,
	output logic                   end_of_record
);

	// queue entry: byte, start flag, file offset
	localparam int QW = 8 + 1 + OFFSET_BITS;

	logic [15:0]            max_len_q;
	logic                   push;
	logic [OFFSET_BITS-1:0] offset;
	logic                   q_full;
	logic                   q_valid;
	logic                   q_pop;
	logic [QW-1:0]          q_rd;
	result_t                res;

	// max record length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// front end: accept and tag each byte with its offset
	ordf_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.q_full       (q_full),
		.start_of_file(start_of_file),
		.push         (push),
		.offset       (offset)
	);

	assign in_stall = q_full;

	// decoupling queue: input stall never looks at out_stall
	ordf_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  ({stream_byte, start_of_file, offset}),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_valid),
		.rd_data  (q_rd)
	);

	// back end: record walk, checksum, padding and result register
	ordf_back #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_len   (max_len_q),
		.q_valid   (q_valid),
		.q_byte    (q_rd[QW-1 -: 8]),
		.q_sof     (q_rd[OFFSET_BITS]),
		.q_offset  (q_rd[OFFSET_BITS-1:0]),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.res_offset(record_offset)
	);

	assign event_res     = res.ev;
	assign record_type   = res.rtype;
	assign payload_byte  = res.pbyte;
	assign payload_index = res.pidx;
	assign record_length = res.rlen;
	assign block_size    = res.blk;
	assign end_of_record = res.eor;

`ifndef SYNTHESIS
	// the checksum byte is always one of the record-closing events
	a_eor_event: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_record) |->
		(event_res == EV_OK || event_res == EV_CSUM || event_res == EV_REPEAT))
		else $error("end_of_record on a non-closing event");

	// a known block size is at least a one-byte header record plus three
	a_blk_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && block_size != '0) |-> (block_size >= 17'd4))
		else $error("library block size below minimum");

	// payload bytes before the checksum sit strictly inside the payload
	a_pidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_PAYLOAD) |-> (payload_index < record_length))
		else $error("payload index beyond record length");

	// the queue is never popped while empty
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");
`endif

endmodule

[hw/rtl/ordf_front.sv]
// ordf_front: input side; tags each accepted byte with its file offset.
// Standalone; feeds ordf_queue in the top level.
module ordf_front #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   q_full,
	input  logic                   start_of_file,
	output logic                   push,
	output logic [OFFSET_BITS-1:0] offset
);

	logic [OFFSET_BITS-1:0] pos_q;

	assign push   = in_valid && !q_full;
	// a start flag puts this byte at offset zero
	assign offset = start_of_file ? '0 : pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= offset + 1'b1;
		end
	end

endmodule

[hw/rtl/ordf_queue.sv]
// ordf_queue: two-entry FIFO between front and back end.
// Standalone; full is registered so stall does not see the output side.
module ordf_queue #(
	parameter int WIDTH = 41
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/ordf_rem.sv]
// ordf_rem: radix-2 restoring remainder, one dividend bit per cycle.
// Standalone; used by ordf_back for the library block boundary.
module ordf_rem #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [OFFSET_BITS-1:0] dividend,
	input  logic [16:0]            divisor,
	output logic                   done,
	output logic [16:0]            remainder
);

	localparam int CW = $clog2(OFFSET_BITS + 1);

	logic                   busy_q;
	logic [CW-1:0]          cnt_q;
	logic [OFFSET_BITS-1:0] dvd_q;
	logic [16:0]            rem_q;
	logic [17:0]            trial;
	logic [17:0]            diff;

	assign trial     = {rem_q, dvd_q[OFFSET_BITS-1]};
	assign diff      = trial - {1'b0, divisor};
	assign done      = busy_q && (cnt_q == '0);
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			rem_q <= (trial >= {1'b0, divisor}) ? diff[16:0] : trial[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(OFFSET_BITS);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			else             cnt_q  <= cnt_q - 1'b1;
		end
	end

endmodule

[hw/rtl/ordf_back.sv]
// ordf_back: record walk state machine, result register and pad sizing.
// Depends on ordf_pkg and ordf_rem.
module ordf_back
	import ordf_pkg::*;
#(
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [15:0]            max_len,
	input  logic                   q_valid,
	input  logic [7:0]             q_byte,
	input  logic                   q_sof,
	input  logic [OFFSET_BITS-1:0] q_offset,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output result_t                res,
	output logic [OFFSET_BITS-1:0] res_offset
);

	phase_t                 phase_q, phase_n, e_phase;
	logic [7:0]             type_q, type_n, e_type;
	logic [15:0]            len_q, len_n, e_len;
	logic [15:0]            left_q, left_n, e_left;
	logic [7:0]             sum_q, sum_n, e_sum;
	logic [16:0]            lib_q, lib_n, e_lib;
	logic [16:0]            bpos_q, bpos_n, e_bpos;
	logic [OFFSET_BITS-1:0] start_q, start_n, e_start;

	logic                   out_valid_q;
	result_t                res_q, res_n;
	logic [OFFSET_BITS-1:0] off_q;

	logic                   fire;
	logic                   partial;
	logic                   rem_start;
	logic                   rem_done;
	logic [16:0]            rem_val;
	logic [16:0]            pad;
	logic                   upd;

	assign fire  = q_valid && (phase_q != PH_DIV) && (!out_valid_q || !out_stall);
	assign q_pop = fire;
	assign upd   = fire || (phase_q == PH_DIV && rem_done);
	assign pad   = (rem_val == '0) ? '0 : (lib_q - rem_val);

	ordf_rem #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (q_offset + 1'b1),
		.divisor  (lib_q),
		.done     (rem_done),
		.remainder(rem_val)
	);

	always_comb begin
		// start flag clears the walk state ahead of this byte
		e_phase = q_sof ? PH_TYPE : phase_q;
		e_type  = q_sof ? '0 : type_q;
		e_len   = q_sof ? '0 : len_q;
		e_left  = q_sof ? '0 : left_q;
		e_sum   = q_sof ? '0 : sum_q;
		e_lib   = q_sof ? '0 : lib_q;
		e_bpos  = q_sof ? '0 : bpos_q;
		e_start = q_sof ? '0 : start_q;

		phase_n   = e_phase;
		type_n    = e_type;
		len_n     = e_len;
		left_n    = e_left;
		sum_n     = e_sum;
		lib_n     = e_lib;
		bpos_n    = e_bpos;
		start_n   = e_start;
		partial   = 1'b0;
		rem_start = 1'b0;
		res_n     = '0;
		res_n.ev  = EV_STOPPED;

		if (fire) begin
			unique case (e_phase)
				PH_PAD: begin
					res_n.ev = EV_PAD;
					bpos_n   = e_bpos - 17'd1;
					if (bpos_n == '0) phase_n = PH_TYPE;
				end
				PH_TYPE: begin
					start_n  = q_offset;
					type_n   = q_byte;
					sum_n    = q_byte;
					len_n    = '0;
					left_n   = '0;
					res_n.ev = EV_HEADER;
					partial  = 1'b1;
					phase_n  = PH_LENLO;
				end
				PH_LENLO: begin
					len_n    = {8'h00, q_byte};
					sum_n    = e_sum + q_byte;
					res_n.ev = EV_HEADER;
					partial  = 1'b1;
					phase_n  = PH_LENHI;
				end
				PH_LENHI: begin
					len_n = {q_byte, e_len[7:0]};
					sum_n = e_sum + q_byte;
					if (e_type == '0 || len_n == '0) begin
						res_n.ev = EV_ZERO;
						phase_n  = PH_STOP;
					end else if (len_n > max_len) begin
						res_n.ev = EV_LONG;
						phase_n  = PH_STOP;
					end else begin
						res_n.ev = EV_HEADER;
						left_n   = len_n;
						phase_n  = PH_BODY;
					end
				end
				PH_BODY: begin
					res_n.pidx  = e_len - e_left;
					res_n.pbyte = q_byte;
					left_n      = e_left - 16'd1;
					sum_n       = e_sum + q_byte;
					if (left_n != '0) begin
						res_n.ev = EV_PAYLOAD;
					end else begin
						res_n.eor = 1'b1;
						if (q_byte != '0 && sum_n != '0) begin
							res_n.ev = EV_CSUM;
							phase_n  = PH_STOP;
						end else if (e_type == TYPE_LIB_HDR && e_lib != '0) begin
							res_n.ev = EV_REPEAT;
							phase_n  = PH_STOP;
						end else begin
							res_n.ev = EV_OK;
							if (e_type == TYPE_LIB_HDR) lib_n = {1'b0, e_len} + LIB_HDR_EXTRA;
							if (e_type == TYPE_LIB_END) begin
								phase_n = PH_STOP;
							end else if ((e_type & MOD_END_MASK) == TYPE_MOD_END) begin
								if (lib_n == '0) begin
									phase_n = PH_STOP;
								end else begin
									// boundary sized by the remainder unit
									phase_n   = PH_DIV;
									rem_start = 1'b1;
								end
							end else begin
								phase_n = PH_TYPE;
							end
						end
					end
				end
				default: begin
					res_n.ev = EV_STOPPED;
					phase_n  = PH_STOP;
				end
			endcase
		end else if (phase_q == PH_DIV && rem_done) begin
			bpos_n  = pad;
			phase_n = (pad != '0) ? PH_PAD : PH_TYPE;
		end

		res_n.rtype = type_n;
		res_n.rlen  = (partial || len_n == '0) ? '0 : (len_n - 16'd1);
		res_n.blk   = lib_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STOP;
			type_q  <= '0;
			len_q   <= '0;
			left_q  <= '0;
			sum_q   <= '0;
			lib_q   <= '0;
			bpos_q  <= '0;
			start_q <= '0;
		end else if (upd) begin
			phase_q <= phase_n;
			type_q  <= type_n;
			len_q   <= len_n;
			left_q  <= left_n;
			sum_q   <= sum_n;
			lib_q   <= lib_n;
			bpos_q  <= bpos_n;
			start_q <= start_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_n;
			off_q <= start_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign res        = res_q;
	assign res_offset = off_q;

endmodule
